/* design/hybsplit_pkg.sv */
`timescale 1ns / 1ps

package hybsplit_pkg;

    localparam int MAX_ELL_WIDTH = 32;
    localparam int COL_W         = 31;
    localparam int INDEX_W       = 32;
    localparam int ROW_W         = 31;
    localparam int VALUE_W       = 64;
    localparam int WIDTH_W       = 6;
    localparam int CFG_DATA_W    = 32;
    localparam int S_TDATA_W     = 96;
    localparam int M_TDATA_W     = 160;

    localparam logic [WIDTH_W-1:0] MAX_ELL_W = WIDTH_W'(MAX_ELL_WIDTH);

    typedef enum logic {
        REG_ELL_WIDTH = 1'b0,
        REG_COL_PITCH = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_ENTRY   = 1'b0,
        REQ_ROW_END = 1'b1
    } req_type_t;

    typedef enum logic {
        SLOT_ELL = 1'b0,
        SLOT_COO = 1'b1
    } slot_kind_t;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_PAD    = 1'b1
    } state_t;

    typedef struct packed {
        logic load_entry;
        logic load_pad_first;
        logic load_pad_next;
        logic row_advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pos_lt_width;
        logic pad_first_last;
        logic pad_next_last;
    } dp_status_t;

endpackage

/* design/hybsplit_ctrl.sv */
`timescale 1ns / 1ps

module hybsplit_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic                     req_type,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  hybsplit_pkg::dp_status_t status,
    output hybsplit_pkg::ctrl_cmd_t  cmd
);

    hybsplit_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic in_xfer;
    logic load;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == hybsplit_pkg::ST_ACCEPT) && out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hybsplit_pkg::ST_ACCEPT: begin
                if (in_xfer && req_type == hybsplit_pkg::REQ_ROW_END
                        && status.pos_lt_width && !status.pad_first_last) begin
                    state_next = hybsplit_pkg::ST_PAD;
                end
            end
            hybsplit_pkg::ST_PAD: begin
                if (out_free && status.pad_next_last) begin
                    state_next = hybsplit_pkg::ST_ACCEPT;
                end
            end
            default: state_next = hybsplit_pkg::ST_ACCEPT;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            hybsplit_pkg::ST_ACCEPT: begin
                if (in_xfer) begin
                    if (req_type == hybsplit_pkg::REQ_ENTRY) begin
                        cmd.load_entry = 1'b1;
                    end else if (status.pos_lt_width) begin
                        cmd.load_pad_first = 1'b1;
                        cmd.row_advance    = status.pad_first_last;
                    end else begin
                        cmd.row_advance = 1'b1;
                    end
                end
            end
            hybsplit_pkg::ST_PAD: begin
                if (out_free) begin
                    cmd.load_pad_next = 1'b1;
                    cmd.row_advance   = status.pad_next_last;
                end
            end
            default: cmd = '0;
        endcase
    end

    assign load = cmd.load_entry || cmd.load_pad_first || cmd.load_pad_next;

    always_comb begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hybsplit_pkg::ST_ACCEPT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/hybsplit_dp.sv */
`timescale 1ns / 1ps

module hybsplit_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [hybsplit_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [hybsplit_pkg::COL_W-1:0]        in_col,
    input  logic [hybsplit_pkg::VALUE_W-1:0]      in_value,
    input  hybsplit_pkg::ctrl_cmd_t               cmd,
    output hybsplit_pkg::dp_status_t              status,
    output logic                                  slot_kind,
    output logic [hybsplit_pkg::INDEX_W-1:0]      slot_address,
    output logic [hybsplit_pkg::ROW_W-1:0]        row_index,
    output logic [hybsplit_pkg::INDEX_W-1:0]      out_col,
    output logic [hybsplit_pkg::VALUE_W-1:0]      out_value,
    output logic                                  last
);

    localparam logic [hybsplit_pkg::INDEX_W-1:0] INDEX_MAX = '1;
    localparam logic [hybsplit_pkg::ROW_W-1:0]   ROW_MAX   = '1;

    logic [hybsplit_pkg::WIDTH_W-1:0] ell_width_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] col_pitch_reg;
    logic [hybsplit_pkg::ROW_W-1:0]   row_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] pos_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] ell_ptr_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] coo_count_reg;
    logic [hybsplit_pkg::WIDTH_W-1:0] pad_pos_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] pad_addr_reg;

    logic                             kind_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] addr_reg;
    logic [hybsplit_pkg::ROW_W-1:0]   row_out_reg;
    logic [hybsplit_pkg::INDEX_W-1:0] col_reg;
    logic [hybsplit_pkg::VALUE_W-1:0] value_reg;
    logic                             last_reg;

    logic [hybsplit_pkg::WIDTH_W-1:0] eff_width;
    logic [hybsplit_pkg::WIDTH_W-1:0] pos_plus1;
    logic [hybsplit_pkg::WIDTH_W-1:0] pad_plus1;
    logic [hybsplit_pkg::ROW_W-1:0]   row_next;

    assign eff_width = (ell_width_reg > hybsplit_pkg::MAX_ELL_W) ?
                       hybsplit_pkg::MAX_ELL_W : ell_width_reg;
    assign pos_plus1 = pos_reg[hybsplit_pkg::WIDTH_W-1:0] + 1'b1;
    assign pad_plus1 = pad_pos_reg + 1'b1;
    assign row_next  = (row_reg == ROW_MAX) ? row_reg : row_reg + 1'b1;

    assign status.pos_lt_width   = pos_reg < {{(hybsplit_pkg::INDEX_W -
                                              hybsplit_pkg::WIDTH_W){1'b0}}, eff_width};
    assign status.pad_first_last = pos_plus1 >= eff_width;
    assign status.pad_next_last  = pad_plus1 >= eff_width;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ell_width_reg <= '0;
            col_pitch_reg <= '0;
        end else if (cfg_write) begin
            if (cfg_index == hybsplit_pkg::REG_ELL_WIDTH) begin
                ell_width_reg <= cfg_data[hybsplit_pkg::WIDTH_W-1:0];
            end else begin
                col_pitch_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            pos_reg       <= '0;
            ell_ptr_reg   <= '0;
            coo_count_reg <= '0;
            pad_pos_reg   <= '0;
            pad_addr_reg  <= '0;
        end else begin
            if (cmd.load_entry) begin
                if (status.pos_lt_width) begin
                    ell_ptr_reg <= ell_ptr_reg + col_pitch_reg;
                end else if (coo_count_reg != INDEX_MAX) begin
                    coo_count_reg <= coo_count_reg + 1'b1;
                end
                if (pos_reg != INDEX_MAX) begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (cmd.load_pad_first) begin
                pad_pos_reg  <= pos_plus1;
                pad_addr_reg <= ell_ptr_reg + col_pitch_reg;
            end
            if (cmd.load_pad_next) begin
                pad_pos_reg  <= pad_plus1;
                pad_addr_reg <= pad_addr_reg + col_pitch_reg;
            end
            if (cmd.row_advance) begin
                row_reg     <= row_next;
                pos_reg     <= '0;
                ell_ptr_reg <= {{(hybsplit_pkg::INDEX_W - hybsplit_pkg::ROW_W){1'b0}},
                                row_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_entry) begin
            kind_reg    <= status.pos_lt_width ? hybsplit_pkg::SLOT_ELL
                                               : hybsplit_pkg::SLOT_COO;
            addr_reg    <= status.pos_lt_width ? ell_ptr_reg : coo_count_reg;
            row_out_reg <= row_reg;
            col_reg     <= {1'b0, in_col};
            value_reg   <= in_value;
            last_reg    <= 1'b1;
        end else if (cmd.load_pad_first || cmd.load_pad_next) begin
            kind_reg    <= hybsplit_pkg::SLOT_ELL;
            addr_reg    <= cmd.load_pad_first ? ell_ptr_reg : pad_addr_reg;
            row_out_reg <= row_reg;
            col_reg     <= '1;
            value_reg   <= '0;
            last_reg    <= cmd.load_pad_first ? status.pad_first_last
                                              : status.pad_next_last;
        end
    end

    assign slot_kind    = kind_reg;
    assign slot_address = addr_reg;
    assign row_index    = row_out_reg;
    assign out_col      = col_reg;
    assign out_value    = value_reg;
    assign last         = last_reg;

endmodule

/* design/csr_to_hybrid_ell_coo_split.sv */
`timescale 1ns / 1ps

// Splits a row-major stream of sparse nonzeros into hybrid ELL + COO slot
// writes. A nonzero entry yields one transfer: an ELL slot at row + column
// pitch * position for the first min(ell_width, 32) entries of a row, a COO
// slot from the running COO count after that. A row-end marker yields one
// padding transfer (column all ones, value zero) per unfilled ELL position,
// one per cycle from the single output register while the output is not
// stalled; the input stays stalled until the last padding transfer is loaded.
// A row-end on a full row yields no transfer. Write ell_width (index 0) and
// the column pitch (index 1) only while idle.
module csr_to_hybrid_ell_coo_split (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [hybsplit_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hybsplit_pkg::S_TDATA_W-1:0]   s_tdata,  // in_col, in_value, pad
    input  logic                                 s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hybsplit_pkg::M_TDATA_W-1:0]   m_tdata,  // slot_address, row_index,
                                                           // out_col, out_value, pad
    output logic                                 m_tuser,  // slot_kind
    output logic                                 m_tlast
);

    hybsplit_pkg::ctrl_cmd_t  cmd;
    hybsplit_pkg::dp_status_t status;

    logic [hybsplit_pkg::INDEX_W-1:0] slot_address;
    logic [hybsplit_pkg::ROW_W-1:0]   row_index;
    logic [hybsplit_pkg::INDEX_W-1:0] out_col;
    logic [hybsplit_pkg::VALUE_W-1:0] out_value;

    assign cfg_ready = 1'b1;

    hybsplit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hybsplit_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_col       (s_tdata[30:0]),
        .in_value     (s_tdata[94:31]),
        .cmd          (cmd),
        .status       (status),
        .slot_kind    (m_tuser),
        .slot_address (slot_address),
        .row_index    (row_index),
        .out_col      (out_col),
        .out_value    (out_value),
        .last         (m_tlast)
    );

    assign m_tdata = {1'b0, out_value, out_col, row_index, slot_address};

endmodule

/* verif/tb_csr_to_hybrid_ell_coo_split.sv */
`timescale 1ns / 1ps

module tb_csr_to_hybrid_ell_coo_split;

    import hybsplit_pkg::*;

    localparam int    DRAIN_CYCLES = 40;
    localparam int    HOLD_CYCLES  = 300;
    localparam time   RUN_LIMIT    = 5_000_000;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    typedef struct {
        req_type_t          kind;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] val;
    } nz_item_t;

    typedef struct packed {
        slot_kind_t         kind;
        logic [INDEX_W-1:0] addr;
        logic [ROW_W-1:0]   row;
        logic [INDEX_W-1:0] col;
        logic [VALUE_W-1:0] val;
        logic               last;
    } slot_write_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_ELL_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    csr_to_hybrid_ell_coo_split dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    nz_item_t    feed_q[$];
    slot_write_t slot_writes_due[$];

    logic [WIDTH_W-1:0] width_reg  = '0;
    logic [INDEX_W-1:0] stride_reg = '0;
    logic [ROW_W-1:0]   row_now    = '0;
    logic [INDEX_W-1:0] row_pos    = '0;
    logic [INDEX_W-1:0] ell_ptr    = '0;
    logic [INDEX_W-1:0] coo_next   = '0;

    int  tx_idle_pct = 15;
    int  rx_idle_pct = 52;
    logic rx_hold    = 1'b0;
    logic hold_arm   = 1'b0;
    logic s_hs       = 1'b0;

    int fail_count   = 0;
    int items_taken  = 0;
    int writes_seen  = 0;
    int ell_due      = 0;
    int coo_due      = 0;
    int pad_due      = 0;
    int row_ends     = 0;

    function automatic void predict_slot_writes(req_type_t kind, logic [COL_W-1:0] col,
                                                logic [VALUE_W-1:0] val);
        logic [INDEX_W-1:0] w;
        logic [INDEX_W-1:0] p;
        logic [INDEX_W-1:0] addr;
        int                 n;
        slot_write_t        sw;
        w = (width_reg > MAX_ELL_W) ? INDEX_W'(MAX_ELL_WIDTH) : INDEX_W'(width_reg);
        sw.row  = row_now;
        if (kind == REQ_ENTRY) begin
            sw.col  = {1'b0, col};
            sw.val  = val;
            sw.last = 1'b1;
            if (row_pos < w) begin
                sw.kind = SLOT_ELL;
                sw.addr = ell_ptr;
                ell_ptr = ell_ptr + stride_reg;
                ell_due++;
            end else begin
                sw.kind = SLOT_COO;
                sw.addr = coo_next;
                if (coo_next != '1) coo_next = coo_next + 1'b1;
                coo_due++;
            end
            if (row_pos != '1) row_pos = row_pos + 1'b1;
            slot_writes_due.push_back(sw);
        end else begin
            p    = row_pos;
            addr = ell_ptr;
            n    = 0;
            while (p < w && n < MAX_ELL_WIDTH) begin
                sw.kind = SLOT_ELL;
                sw.addr = addr;
                sw.col  = '1;
                sw.val  = '0;
                sw.last = (p + 1'b1 >= w) || (n + 1 == MAX_ELL_WIDTH);
                slot_writes_due.push_back(sw);
                addr = addr + stride_reg;
                p    = p + 1'b1;
                n++;
                pad_due++;
            end
            if (row_now != ROW_MAX) row_now = row_now + 1'b1;
            row_pos = '0;
            ell_ptr = {1'b0, row_now};
            row_ends++;
        end
    endfunction

    always @(posedge aclk) begin
        s_hs <= s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (s_hs) void'(feed_q.pop_front());
        if (s_tvalid && !s_hs) begin
            s_tvalid <= 1'b1;
        end else if ((feed_q.size() > (s_hs ? 0 : 0)) && feed_q.size() != 0
                     && $urandom_range(99) >= tx_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, feed_q[0].val, feed_q[0].col};
            s_tuser  <= feed_q[0].kind;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        slot_write_t got;
        slot_write_t want;
        if (aresetn && s_tvalid && s_tready) begin
            predict_slot_writes(req_type_t'(s_tuser), s_tdata[COL_W-1:0],
                                s_tdata[COL_W +: VALUE_W]);
            items_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = slot_kind_t'(m_tuser);
            got.addr = m_tdata[INDEX_W-1:0];
            got.row  = m_tdata[INDEX_W +: ROW_W];
            got.col  = m_tdata[INDEX_W + ROW_W +: INDEX_W];
            got.val  = m_tdata[2 * INDEX_W + ROW_W +: VALUE_W];
            got.last = m_tlast;
            writes_seen++;
            if (slot_writes_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected kind %0d addr %h row %h col %h val %h last %b",
                             $realtime, got.kind, got.addr, got.row, got.col, got.val, got.last);
            end else begin
                want = slot_writes_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch on transfer %0d", $realtime, writes_seen);
                        $display("  expected kind %0d addr %h row %h col %h val %h last %b",
                                 want.kind, want.addr, want.row, want.col, want.val, want.last);
                        $display("  actual   kind %0d addr %h row %h col %h val %h last %b",
                                 got.kind, got.addr, got.row, got.col, got.val, got.last);
                    end
                end
            end
        end
    end

    initial begin
        wait (hold_arm);
        repeat (10) @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void push_item(req_type_t kind, logic [COL_W-1:0] col,
                                      logic [VALUE_W-1:0] val);
        nz_item_t it;
        it.kind = kind;
        it.col  = col;
        it.val  = val;
        feed_q.push_back(it);
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_ELL_WIDTH) width_reg = data[WIDTH_W-1:0];
        else                      stride_reg = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (feed_q.size() != 0 || slot_writes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_rows(int n_items, int w);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(9) == 0) len = $urandom_range(w, w + 12);
            else                        len = $urandom_range(0, w + 2);
            for (int i = 0; i < len && left > 1; i++) begin
                push_item(REQ_ENTRY, COL_W'($urandom), {$urandom, $urandom});
                left--;
            end
            push_item(REQ_ROW_END, COL_W'($urandom), {$urandom, $urandom});
            left--;
        end
    endtask

    task automatic set_width(int w);
        write_reg(REG_ELL_WIDTH, {26'($urandom), 6'(w)});
    endtask

    initial begin
        int w;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_width(3);
        write_reg(REG_COL_PITCH, 32'd5);
        push_item(REQ_ENTRY, '1, '1);
        push_item(REQ_ENTRY, '0, '0);
        push_item(REQ_ENTRY, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555);
        push_item(REQ_ENTRY, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_item(REQ_ROW_END, '0, '0);
        push_item(REQ_ENTRY, 31'd17, 64'h1234_5678_9ABC_DEF0);
        push_item(REQ_ROW_END, '1, '1);
        push_item(REQ_ROW_END, '0, '0);
        push_item(REQ_ENTRY, 31'd3, 64'hDEAD_BEEF_0000_0001);
        wait_idle();

        set_width(63);
        write_reg(REG_COL_PITCH, 32'hFFFF_FFF0);
        push_item(REQ_ENTRY, 31'd9, 64'h8000_0000_0000_0000);
        push_item(REQ_ROW_END, '0, '0);
        push_item(REQ_ROW_END, '0, '0);
        wait_idle();

        set_width(0);
        write_reg(REG_COL_PITCH, 32'd0);
        push_item(REQ_ENTRY, '1, 64'd1);
        push_item(REQ_ENTRY, '0, '1);
        push_item(REQ_ROW_END, '0, '0);
        wait_idle();

        set_width(32);
        write_reg(REG_COL_PITCH, 32'hFFFF_FFFF);
        push_item(REQ_ENTRY, 31'd1, 64'd2);
        push_item(REQ_ROW_END, '0, '0);
        push_item(REQ_ENTRY, 31'd4, 64'd8);
        wait_idle();

        w = $urandom_range(1, 8);
        set_width(w);
        write_reg(REG_COL_PITCH, $urandom);
        queue_rows(160, w);
        wait_idle();

        tx_idle_pct = 52;
        rx_idle_pct = 15;
        w = $urandom_range(0, 63);
        set_width(w);
        write_reg(REG_COL_PITCH, $urandom);
        queue_rows(160, (w > MAX_ELL_WIDTH) ? MAX_ELL_WIDTH : w);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_width(4);
        write_reg(REG_COL_PITCH, $urandom);
        queue_rows(160, 4);
        hold_arm = 1'b1;
        wait_idle();

        $display("%0d items taken (%0d row ends), %0d slot transfers checked",
                 items_taken, row_ends, writes_seen);
        $display("  %0d ELL entries, %0d COO entries, %0d ELL padding slots, %0d mismatches",
                 ell_due, coo_due, pad_due, fail_count);
        if (fail_count == 0 && slot_writes_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/hybsplit_pkg.sv
design/hybsplit_ctrl.sv
design/hybsplit_dp.sv
design/csr_to_hybrid_ell_coo_split.sv
verif/tb_csr_to_hybrid_ell_coo_split.sv
